// ===== rtl/usb_phy_power_clock_sequencer_defines.svh =====
// assertion macros for the usb phy power and clock sequencer checker
// expects clk and rst in scope where a macro is used
`ifndef USB_PHY_POWER_CLOCK_SEQUENCER_DEFINES_SVH
`define USB_PHY_POWER_CLOCK_SEQUENCER_DEFINES_SVH

// same-cycle implication, off during reset
`define UPCS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define UPCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// what must hold in the cycle after reset is seen
`define UPCS_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== rtl/upcs_pkg.sv =====
// shared types, codes and helpers for the usb phy power and clock sequencer
// no dependencies
package upcs_pkg;

  localparam int NUM_PORTS = 3;
  localparam int PORT_W    = 2;
  localparam int TICK_W    = 16;

  typedef logic [NUM_PORTS-1:0] port_mask_t;
  typedef logic [PORT_W-1:0]    port_idx_t;
  typedef logic [TICK_W-1:0]    tick_cnt_t;

  localparam port_idx_t DUAL_ROLE_PORT   = 2'd2;
  localparam tick_cnt_t RESET_WAIT_TICKS = 16'd1000;

  typedef enum logic [1:0] {
    CMD_SET_MODE  = 2'd0,
    CMD_POWER_ON  = 2'd1,
    CMD_POWER_OFF = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_DONE    = 2'd0,
    OUT_WAIT    = 2'd1,
    OUT_TIMEOUT = 2'd2,
    OUT_BUSY    = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LDO  = 3'b010,
    PH_PLL  = 3'b100
  } phase_t;

  typedef struct packed {
    cmd_t      command;
    port_idx_t port_index;
    logic      want_host;
    logic      ldo_ready;
    logic      pll_locked;
  } item_t;

  typedef struct packed {
    outcome_t   outcome;
    port_mask_t power_mask;
    port_idx_t  clock_source;
    logic       host_ctrl_on;
    logic       device_ctrl_on;
    logic       port2_host_selected;
    logic       suspend_resume_off;
  } result_t;

  // one-hot bit of a port, zero for an index past the last port
  function automatic port_mask_t port_bit(port_idx_t p);
    port_mask_t m;
    m = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (p == PORT_W'(i)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/usb_phy_power_clock_sequencer.sv =====
// usb phy power and clock sequencer
// input channel: in_valid / in_stall with command, port_index, want_host,
//   ldo_ready and pll_locked; one command or status tick per transaction
// output channel: out_valid / out_stall, one result transaction per input
//   transaction, in order, carrying outcome and the power, clock and
//   controller enable state after that transaction
// configuration: cfg_valid / cfg_ready write of lock_wait_ticks, the tick
//   budget for each status wait; cfg_ready is always high, write only idle
// data path: an accepted transaction sits in the input register, its result is
//   then loaded into the result register, where it waits until it is taken
// throughput: one transaction per cycle unless the receiver stalls; state update
//   and result are one combinational pass between input and result register
// when the receiver stalls the result holds and the input register still
//   takes one more transaction; after that in_stall rises
// reset: ports unpowered, device mode, clock source port 0, controllers off,
//   no power-up pending, lock_wait_ticks back to 1000, both registers empty
// depends on upcs_pkg, upcs_in_reg, upcs_core, upcs_out_reg
module usb_phy_power_clock_sequencer import upcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [1:0]  port_index,
  input  logic        want_host,
  input  logic        ldo_ready,
  input  logic        pll_locked,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  outcome,
  output logic [NUM_PORTS-1:0] power_mask,
  output logic [1:0]  clock_source,
  output logic        host_ctrl_on,
  output logic        device_ctrl_on,
  output logic        port2_host_selected,
  output logic        suspend_resume_off,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    out_ready;
  logic    fire;
  result_t res;
  result_t res_q;

  assign in_item.command    = cmd_t'(command);
  assign in_item.port_index = port_index;
  assign in_item.want_host  = want_host;
  assign in_item.ldo_ready  = ldo_ready;
  assign in_item.pll_locked = pll_locked;

  assign cfg_ready = 1'b1;
  assign fire      = hold_valid && out_ready;

  upcs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  upcs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .fire     (fire),
    .item     (hold_item),
    .res      (res)
  );

  upcs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .out_stall (out_stall),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign outcome             = res_q.outcome;
  assign power_mask          = res_q.power_mask;
  assign clock_source        = res_q.clock_source;
  assign host_ctrl_on        = res_q.host_ctrl_on;
  assign device_ctrl_on      = res_q.device_ctrl_on;
  assign port2_host_selected = res_q.port2_host_selected;
  assign suspend_resume_off  = res_q.suspend_resume_off;

endmodule

// ===== rtl/upcs_in_reg.sv =====
// input register stage of the sequencer: holds one accepted transaction
// depends on upcs_pkg
module upcs_in_reg import upcs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_stall,
  input  logic  take,
  output logic  hold_valid,
  output item_t hold_item
);

  logic full;
  logic full_next;
  logic load;

  assign in_stall   = full && !take;
  assign load       = in_valid && !in_stall;
  assign hold_valid = full;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_item <= in_item;
    end
  end

endmodule

// ===== rtl/upcs_core.sv =====
// sequencer state and next-state logic: power, mode, clock owner, wait timer
// depends on upcs_pkg
module upcs_core import upcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  tick_cnt_t cfg_data,
  input  logic      fire,
  input  item_t     item,
  output result_t   res
);

  tick_cnt_t  wait_cfg;
  port_mask_t powered, powered_next;
  port_mask_t host_role, host_role_next;
  port_idx_t  owner, owner_next;
  logic       host_en, host_en_next;
  logic       dev_en, dev_en_next;
  logic       dual_sel, dual_sel_next;
  logic       susp_dis, susp_dis_next;
  phase_t     phase, phase_next;
  port_idx_t  pending, pending_next;
  tick_cnt_t  ticks_left, ticks_left_next;

  tick_cnt_t  budget;
  logic       down_req;
  logic       up_req;
  port_idx_t  act_port;
  logic       owner_ok;
  logic       dual_dev;
  port_mask_t cand;
  logic       found;
  port_idx_t  pick;
  outcome_t   outcome;
  logic       ok;

  assign budget = (wait_cfg == '0) ? tick_cnt_t'(1) : wait_cfg;

  always_comb begin
    powered_next    = powered;
    host_role_next  = host_role;
    owner_next      = owner;
    host_en_next    = host_en;
    dev_en_next     = dev_en;
    dual_sel_next   = dual_sel;
    susp_dis_next   = susp_dis;
    phase_next      = phase;
    pending_next    = pending;
    ticks_left_next = ticks_left;
    outcome         = OUT_DONE;
    down_req        = 1'b0;
    up_req          = 1'b0;
    act_port        = item.port_index;
    ok              = (phase == PH_LDO) ? item.ldo_ready : item.pll_locked;

    if (item.command == CMD_TICK) begin
      if (phase != PH_IDLE) begin
        act_port = pending;
        if (ok) begin
          if (phase == PH_LDO) begin
            phase_next      = PH_PLL;
            ticks_left_next = budget;
            outcome         = OUT_WAIT;
          end else begin
            phase_next = PH_IDLE;
            up_req     = 1'b1;
          end
        end else if (ticks_left <= tick_cnt_t'(1)) begin
          phase_next      = PH_IDLE;
          ticks_left_next = '0;
          down_req        = 1'b1;
          outcome         = OUT_TIMEOUT;
        end else begin
          ticks_left_next = ticks_left - tick_cnt_t'(1);
          outcome         = OUT_WAIT;
        end
      end
    end else if (phase != PH_IDLE) begin
      outcome = OUT_BUSY;
    end else if (item.port_index < PORT_W'(NUM_PORTS)) begin
      unique case (item.command)
        CMD_SET_MODE: begin
          if (item.want_host) begin
            host_role_next = host_role | port_bit(item.port_index);
          end else begin
            host_role_next = host_role & ~port_bit(item.port_index);
          end
          if (item.port_index == DUAL_ROLE_PORT) begin
            if (item.want_host) begin
              dual_sel_next = 1'b1;
            end else begin
              susp_dis_next = 1'b1;
            end
          end
        end
        CMD_POWER_ON: begin
          phase_next      = PH_LDO;
          pending_next    = item.port_index;
          ticks_left_next = budget;
          outcome         = OUT_WAIT;
        end
        CMD_POWER_OFF: begin
          down_req = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // dual-role port in device mode sets the device controller, not the owner
    dual_dev = (act_port == DUAL_ROLE_PORT) && ((host_role_next & port_bit(act_port)) == '0);

    if (down_req) begin
      powered_next = powered_next & ~port_bit(act_port);
    end else if (up_req) begin
      powered_next = powered_next | port_bit(act_port);
    end

    owner_ok = (owner < PORT_W'(NUM_PORTS)) && ((powered_next & port_bit(owner)) != '0);

    // when the owner goes down, the lowest powered host-mode port takes the clock
    cand  = powered_next & host_role_next;
    found = 1'b0;
    pick  = '0;
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        pick  = PORT_W'(i);
      end
    end

    if (down_req) begin
      if (dual_dev) begin
        dev_en_next = 1'b0;
      end else if (!found) begin
        host_en_next = 1'b0;
      end else if (owner == act_port || !owner_ok) begin
        owner_next = pick;
      end
    end else if (up_req) begin
      if (dual_dev) begin
        dev_en_next = 1'b1;
      end else if (!owner_ok) begin
        owner_next = act_port;
      end
      host_en_next = 1'b1;
    end

    res.outcome             = outcome;
    res.power_mask          = powered_next
                              | ((phase_next != PH_IDLE) ? port_bit(pending_next) : '0);
    res.clock_source        = owner_next;
    res.host_ctrl_on        = host_en_next;
    res.device_ctrl_on      = dev_en_next;
    res.port2_host_selected = dual_sel_next;
    res.suspend_resume_off  = susp_dis_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_cfg <= RESET_WAIT_TICKS;
    end else if (cfg_we) begin
      wait_cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      powered    <= '0;
      host_role  <= '0;
      owner      <= '0;
      host_en    <= 1'b0;
      dev_en     <= 1'b0;
      dual_sel   <= 1'b0;
      susp_dis   <= 1'b0;
      phase      <= PH_IDLE;
      pending    <= '0;
      ticks_left <= '0;
    end else if (fire) begin
      powered    <= powered_next;
      host_role  <= host_role_next;
      owner      <= owner_next;
      host_en    <= host_en_next;
      dev_en     <= dev_en_next;
      dual_sel   <= dual_sel_next;
      susp_dis   <= susp_dis_next;
      phase      <= phase_next;
      pending    <= pending_next;
      ticks_left <= ticks_left_next;
    end
  end

endmodule

// ===== rtl/upcs_out_reg.sv =====
// result register of the sequencer with valid flag and downstream stall
// depends on upcs_pkg
module upcs_out_reg import upcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_ready,
  output logic    out_valid,
  output result_t res_q
);

  logic valid;

  assign out_ready = !valid || !out_stall;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_ready) begin
      valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

endmodule

// ===== rtl/upcs_checker.sv =====
// port-level checker for the usb phy power and clock sequencer, bound to the top
// depends on upcs_pkg and usb_phy_power_clock_sequencer_defines.svh
`include "usb_phy_power_clock_sequencer_defines.svh"

module upcs_checker import upcs_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           outcome,
  input logic [NUM_PORTS-1:0] power_mask,
  input logic [1:0]           clock_source
);

  // no result left over after reset
  `UPCS_ASSERT_RESET(a_reset_empty, !out_valid, "result valid after reset")

  // a stalled result transaction stays put
  `UPCS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(outcome) && $stable(power_mask) && $stable(clock_source), "stalled result changed")

  // a pending power-up shows in the mask, so a waiting result never has it empty
  `UPCS_ASSERT_IMP(a_wait_mask, out_valid && outcome == OUT_WAIT, power_mask != '0, "waiting with empty power mask")

  // clock owner always names a real port
  `UPCS_ASSERT_IMP(a_owner_range, out_valid, clock_source < PORT_W'(NUM_PORTS), "clock source out of range")

endmodule

bind usb_phy_power_clock_sequencer upcs_checker u_upcs_checker (.*);

// ===== sim/usb_phy_power_clock_sequencer_tb.sv =====
// self-checking testbench for usb_phy_power_clock_sequencer: directed plan, then random traffic
// carries its own model of the power-up sequence and checks every result transaction
// depends on upcs_pkg and the rtl of the sequencer
`timescale 1ns / 100ps

module usb_phy_power_clock_sequencer_tb;
  import upcs_pkg::*;

  localparam int RUN_LIMIT    = 500000;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           command = '0;
  logic [1:0]           port_index = '0;
  logic                 want_host = 1'b0;
  logic                 ldo_ready = 1'b0;
  logic                 pll_locked = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           outcome;
  logic [NUM_PORTS-1:0] power_mask;
  logic [1:0]           clock_source;
  logic                 host_ctrl_on;
  logic                 device_ctrl_on;
  logic                 port2_host_selected;
  logic                 suspend_resume_off;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [15:0]          cfg_data = '0;

  usb_phy_power_clock_sequencer u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .command             (command),
    .port_index          (port_index),
    .want_host           (want_host),
    .ldo_ready           (ldo_ready),
    .pll_locked          (pll_locked),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .outcome             (outcome),
    .power_mask          (power_mask),
    .clock_source        (clock_source),
    .host_ctrl_on        (host_ctrl_on),
    .device_ctrl_on      (device_ctrl_on),
    .port2_host_selected (port2_host_selected),
    .suspend_resume_off  (suspend_resume_off),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always #6 clk = ~clk;

  // sequencer state as the testbench sees it
  port_mask_t sq_powered;
  port_mask_t sq_host_role;
  port_idx_t  sq_clk_src;
  logic       sq_host_on;
  logic       sq_dev_on;
  logic       sq_p2_host;
  logic       sq_susp_off;
  phase_t     sq_phase;
  port_idx_t  sq_pend_port;
  tick_cnt_t  sq_ticks_left;
  tick_cnt_t  sq_lock_ticks;

  result_t awaited_results[$];

  bit calm = 1'b0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int budgets_used = 0;
  int outcome_seen[4];
  int cycle_count = 0;

  typedef struct {
    bit        is_cfg;
    tick_cnt_t value;
    item_t     it;
    bit        typed;
    result_t   res;
  } plan_row_t;

  plan_row_t directed_plan[$];

  function automatic port_mask_t port_onehot(port_idx_t p);
    return port_mask_t'(1) << p;
  endfunction

  // port going down: release the device controller, move the host clock source or turn the host off
  function automatic void take_down(port_idx_t p);
    bit         found;
    port_idx_t  pick;
    port_mask_t live_hosts;
    found = 1'b0;
    pick = '0;
    sq_powered &= ~port_onehot(p);
    if (p == DUAL_ROLE_PORT && (sq_host_role & port_onehot(p)) == '0) begin
      sq_dev_on = 1'b0;
    end else begin
      live_hosts = sq_powered & sq_host_role;
      for (int i = NUM_PORTS - 1; i >= 0; i--) begin
        if (live_hosts[i]) begin
          found = 1'b1;
          pick = port_idx_t'(i);
        end
      end
      if (!found) begin
        sq_host_on = 1'b0;
      end else if (sq_clk_src == p || sq_clk_src >= NUM_PORTS ||
                   (sq_powered & port_onehot(sq_clk_src)) == '0) begin
        sq_clk_src = pick;
      end
    end
  endfunction

  function automatic result_t predict_sequencer(item_t it);
    result_t   r;
    outcome_t  oc;
    tick_cnt_t budget;
    logic      status_ok;
    budget = (sq_lock_ticks == '0) ? tick_cnt_t'(1) : sq_lock_ticks;
    oc = OUT_DONE;
    if (it.command == CMD_TICK) begin
      if (sq_phase != PH_IDLE) begin
        status_ok = (sq_phase == PH_LDO) ? it.ldo_ready : it.pll_locked;
        if (status_ok) begin
          if (sq_phase == PH_LDO) begin
            sq_phase = PH_PLL;
            sq_ticks_left = budget;
            oc = OUT_WAIT;
          end else begin
            sq_phase = PH_IDLE;
            sq_powered |= port_onehot(sq_pend_port);
            if (sq_pend_port == DUAL_ROLE_PORT &&
                (sq_host_role & port_onehot(sq_pend_port)) == '0) begin
              sq_dev_on = 1'b1;
            end else if (sq_clk_src >= NUM_PORTS ||
                         (sq_powered & port_onehot(sq_clk_src)) == '0) begin
              sq_clk_src = sq_pend_port;
            end
            sq_host_on = 1'b1;
            oc = OUT_DONE;
          end
        end else if (sq_ticks_left <= 1) begin
          sq_phase = PH_IDLE;
          sq_ticks_left = '0;
          take_down(sq_pend_port);
          oc = OUT_TIMEOUT;
        end else begin
          sq_ticks_left--;
          oc = OUT_WAIT;
        end
      end
    end else if (sq_phase != PH_IDLE) begin
      oc = OUT_BUSY;
    end else if (it.port_index < NUM_PORTS) begin
      case (it.command)
        CMD_SET_MODE: begin
          if (it.want_host) sq_host_role |= port_onehot(it.port_index);
          else sq_host_role &= ~port_onehot(it.port_index);
          if (it.port_index == DUAL_ROLE_PORT) begin
            if (it.want_host) sq_p2_host = 1'b1;
            else sq_susp_off = 1'b1;
          end
        end
        CMD_POWER_ON: begin
          sq_phase = PH_LDO;
          sq_pend_port = it.port_index;
          sq_ticks_left = budget;
          oc = OUT_WAIT;
        end
        default: take_down(it.port_index);
      endcase
    end
    r.outcome = oc;
    r.power_mask = sq_powered | ((sq_phase != PH_IDLE) ? port_onehot(sq_pend_port) : '0);
    r.clock_source = sq_clk_src;
    r.host_ctrl_on = sq_host_on;
    r.device_ctrl_on = sq_dev_on;
    r.port2_host_selected = sq_p2_host;
    r.suspend_resume_off = sq_susp_off;
    return r;
  endfunction

  // mostly back to back, some short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic item_t cmd_item(cmd_t c, logic [1:0] p, logic h, logic l, logic k);
    item_t it;
    it.command = c;
    it.port_index = p;
    it.want_host = h;
    it.ldo_ready = l;
    it.pll_locked = k;
    return it;
  endfunction

  function automatic void add_step(item_t it);
    plan_row_t row;
    row = '{default: '0};
    row.it = it;
    directed_plan.push_back(row);
  endfunction

  // rows whose result is plain: only outcome and power mask can be non-zero
  function automatic void add_known(item_t it, outcome_t o, port_mask_t m);
    plan_row_t row;
    row = '{default: '0};
    row.it = it;
    row.typed = 1'b1;
    row.res = '0;
    row.res.outcome = o;
    row.res.power_mask = m;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_budget(tick_cnt_t v);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.value = v;
    directed_plan.push_back(row);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    int      n;
    result_t pred;
    n = idle_len();
    if (n != 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    command = it.command;
    port_index = it.port_index;
    want_host = it.want_host;
    ldo_ready = it.ldo_ready;
    pll_locked = it.pll_locked;
    do @(posedge clk); while (in_stall);
    pred = predict_sequencer(it);
    awaited_results.push_back(typed ? typed_res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // budget register is only written with the sequencer drained
  task automatic write_lock_ticks(input tick_cnt_t v);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sq_lock_ticks = v;
    budgets_used++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    bit      bad;
    if (!rst && out_valid && !out_stall) begin
      got.outcome = outcome_t'(outcome);
      got.power_mask = power_mask;
      got.clock_source = clock_source;
      got.host_ctrl_on = host_ctrl_on;
      got.device_ctrl_on = device_ctrl_on;
      got.port2_host_selected = port2_host_selected;
      got.suspend_resume_off = suspend_resume_off;
      results_seen++;
      outcome_seen[outcome]++;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] result with nothing awaited: %p", $realtime, got);
      end else begin
        want = awaited_results.pop_front();
        bad = (got.outcome !== want.outcome) || (got.power_mask !== want.power_mask) ||
              (got.clock_source !== want.clock_source) ||
              (got.host_ctrl_on !== want.host_ctrl_on) ||
              (got.device_ctrl_on !== want.device_ctrl_on) ||
              (got.port2_host_selected !== want.port2_host_selected) ||
              (got.suspend_resume_off !== want.suspend_resume_off);
        if (bad) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] result %0d mismatch", $realtime, results_seen);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("** usb_phy_power_clock_sequencer: FAILED **");
      $finish;
    end
  end

  // receiver side: random stall bursts
  initial begin : rx_side
    int hold;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall = 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        hold = idle_len();
        if (hold != 0) begin
          out_stall = 1'b1;
          hold--;
        end
      end
    end
  end

  initial begin : stimulus
    tick_cnt_t  budgets[6];
    int         phase_items;
    int         pick;
    int         ready_pct;
    logic [1:0] p;
    plan_row_t  row;

    sq_powered = '0;
    sq_host_role = '0;
    sq_clk_src = '0;
    sq_host_on = 1'b0;
    sq_dev_on = 1'b0;
    sq_p2_host = 1'b0;
    sq_susp_off = 1'b0;
    sq_phase = PH_IDLE;
    sq_pend_port = '0;
    sq_ticks_left = '0;
    sq_lock_ticks = RESET_WAIT_TICKS;
    for (int i = 0; i < 4; i++) outcome_seen[i] = 0;

    // reset state, out of range port, power off with nothing up
    add_known(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b1, 1'b1), OUT_DONE, 3'b000);
    add_known(cmd_item(CMD_SET_MODE, 2'd3, 1'b1, 1'b0, 1'b0), OUT_DONE, 3'b000);
    add_step(cmd_item(CMD_POWER_OFF, 2'd0, 1'b0, 1'b0, 1'b0));
    // zero budget behaves as one tick
    add_budget(16'd0);
    add_known(cmd_item(CMD_POWER_ON, 2'd0, 1'b0, 1'b0, 1'b0), OUT_WAIT, 3'b001);
    add_known(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b0, 1'b1), OUT_TIMEOUT, 3'b000);
    add_step(cmd_item(CMD_SET_MODE, 2'd0, 1'b1, 1'b0, 1'b0));
    add_step(cmd_item(CMD_POWER_ON, 2'd0, 1'b0, 1'b0, 1'b0));
    add_known(cmd_item(CMD_SET_MODE, 2'd1, 1'b1, 1'b1, 1'b1), OUT_BUSY, 3'b001);
    add_step(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b1, 1'b0));
    add_step(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b0, 1'b1));
    add_budget(16'd3);
    // dual-role port in device mode
    add_step(cmd_item(CMD_SET_MODE, 2'd2, 1'b0, 1'b0, 1'b0));
    add_step(cmd_item(CMD_POWER_ON, 2'd2, 1'b0, 1'b0, 1'b0));
    add_step(cmd_item(CMD_TICK, 2'd3, 1'b1, 1'b1, 1'b0));
    add_step(cmd_item(CMD_TICK, 2'd1, 1'b0, 1'b1, 1'b0));
    add_step(cmd_item(CMD_TICK, 2'd2, 1'b1, 1'b0, 1'b1));
    // second host port, then the clock owner goes down
    add_step(cmd_item(CMD_SET_MODE, 2'd1, 1'b1, 1'b0, 1'b0));
    add_step(cmd_item(CMD_POWER_ON, 2'd1, 1'b0, 1'b0, 1'b0));
    add_step(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b1, 1'b1));
    add_step(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b1, 1'b1));
    add_step(cmd_item(CMD_POWER_OFF, 2'd0, 1'b0, 1'b0, 1'b0));
    // power on again an already powered port, run out of budget
    add_step(cmd_item(CMD_POWER_ON, 2'd1, 1'b0, 1'b0, 1'b0));
    add_step(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b0, 1'b1));
    add_step(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b0, 1'b1));
    add_step(cmd_item(CMD_TICK, 2'd0, 1'b0, 1'b0, 1'b1));
    add_step(cmd_item(CMD_SET_MODE, 2'd2, 1'b1, 1'b0, 1'b0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_cfg) write_lock_ticks(row.value);
      else send_item(row.it, row.typed, row.res);
    end

    budgets[0] = 16'd1;
    budgets[1] = 16'd2;
    budgets[2] = tick_cnt_t'($urandom_range(3, 12));
    budgets[3] = 16'hFFFF;
    budgets[4] = 16'd0;
    budgets[5] = tick_cnt_t'($urandom_range(13, 65535));

    for (int b = 0; b < 6; b++) begin
      write_lock_ticks(budgets[b]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 3) calm = ~calm;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // power-up with a random chance of the awaited status on each tick
          case ($urandom_range(0, 2))
            0: ready_pct = 5;
            1: ready_pct = 35;
            default: ready_pct = 85;
          endcase
          p = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
          send_item(cmd_item(CMD_POWER_ON, p, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);
          phase_items++;
          while (sq_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < 6)
              send_item(cmd_item(cmd_t'($urandom_range(0, 2)), 2'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1))), 1'b0, '0);
            else
              send_item(cmd_item(CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 99) < ready_pct),
                                 1'($urandom_range(0, 99) < ready_pct)), 1'b0, '0);
            phase_items++;
          end
        end else if (pick < 65) begin
          send_item(cmd_item(CMD_SET_MODE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);
          phase_items++;
        end else if (pick < 80) begin
          send_item(cmd_item(CMD_POWER_OFF, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);
          phase_items++;
        end else begin
          // noise: any field values at all
          send_item(cmd_item(cmd_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))), 1'b0, '0);
          phase_items++;
        end
      end
    end

    in_valid = 1'b0;
    calm = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d transactions under %0d tick budgets (0, 1 and 65535 among them)",
             items_sent, budgets_used);
    $display("results checked %0d: done %0d, waiting %0d, timed out %0d, busy %0d",
             results_seen, outcome_seen[OUT_DONE], outcome_seen[OUT_WAIT],
             outcome_seen[OUT_TIMEOUT], outcome_seen[OUT_BUSY]);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("** usb_phy_power_clock_sequencer: PASSED **");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count,
               awaited_results.size());
      $display("** usb_phy_power_clock_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
